FILE: rtl/dsrm_pkg.sv
// ----------------------------------------------------------------------------
// dsrm_pkg: shared types and constants of the dot-star matcher
// Holds the command codes, the special pattern bytes, the item structs and
// the structs that run between the matcher cells.
// ----------------------------------------------------------------------------
package dsrm_pkg;

    // Largest pattern the cell row can hold.
    localparam int PATTERN_MAX = 32;
    // Width of the pattern length count, which must reach PATTERN_MAX itself.
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    // Command codes carried by an input item.
    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_APPEND  = 2'd1;
    localparam logic [1:0] CMD_START   = 2'd2;
    localparam logic [1:0] CMD_SUBJECT = 2'd3;

    // Pattern bytes with a special meaning.
    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] DOT_BYTE  = 8'h2E;

    // One input item.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic matched;
        logic pattern_error;
    } t_out_item;

    // Per-cell control, decoded once in the top level.
    typedef struct packed {
        logic row_en;      // update the row bit this cycle
        logic wr_en;       // this cell takes the appended pattern byte
        logic active;      // cell index lies within the new pattern length
        logic first;       // cell holds pattern position one
        logic empty_mode;  // compute the row for the empty subject
    } t_cell_ctrl;

    // Data handed from one cell to the next one up the row.
    typedef struct packed {
        logic       bit_new;       // new row bit of the sending cell
        logic       bit_new_prev;  // new row bit one position lower
        logic       bit_old;       // stored row bit of the sending cell
        logic [7:0] pat;           // pattern byte of the sending cell
    } t_cell_link;

endpackage

FILE: rtl/dsrm_cell.sv
// ----------------------------------------------------------------------------
// dsrm_cell: one position of the matcher row
// Holds one pattern byte and one match bit, and computes the new match bit
// from its neighbor below and the current subject byte.
// ----------------------------------------------------------------------------
module dsrm_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dsrm_pkg::t_cell_ctrl i_ctrl,
    input  logic [7:0]           i_data_byte,
    input  dsrm_pkg::t_cell_link i_link,
    output dsrm_pkg::t_cell_link o_link
);
    import dsrm_pkg::*;

    logic [7:0] r_pat;
    logic       r_bit;
    logic [7:0] n_pat_eff;
    logic       n_bit;
    logic       fits_self;
    logic       fits_prev;

    // The byte being appended is seen at once, so the empty-subject row
    // already reflects the longer pattern.
    assign n_pat_eff = i_ctrl.wr_en ? i_data_byte : r_pat;
    assign fits_self = (n_pat_eff == DOT_BYTE) || (n_pat_eff == i_data_byte);
    assign fits_prev = (i_link.pat == DOT_BYTE) || (i_link.pat == i_data_byte);

    // New match bit. A star either skips its element (two positions down in
    // the new row) or repeats the element below it once more.
    always_comb begin
        if (!i_ctrl.active) begin
            n_bit = 1'b0;
        end else if (n_pat_eff != STAR_BYTE) begin
            n_bit = !i_ctrl.empty_mode && i_link.bit_old && fits_self;
        end else if (i_ctrl.first) begin
            n_bit = 1'b0;
        end else begin
            n_bit = i_link.bit_new_prev ||
                    (!i_ctrl.empty_mode && fits_prev && r_bit);
        end
    end

    // Row bit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_ctrl.row_en) begin
            r_bit <= n_bit;
        end
    end

    // Pattern byte register.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_pat <= i_data_byte;
        end
    end

    // Hand the results up to the next cell.
    assign o_link.bit_new      = n_bit;
    assign o_link.bit_new_prev = i_link.bit_new;
    assign o_link.bit_old      = r_bit;
    assign o_link.pat          = n_pat_eff;

endmodule

FILE: rtl/dsrm_out_skid.sv
// ----------------------------------------------------------------------------
// dsrm_out_skid: output register with a skid entry
// Holds up to two result items so the matcher keeps taking input items while
// the downstream side stalls, until the skid entry is full as well.
// ----------------------------------------------------------------------------
module dsrm_out_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_valid,
    input  dsrm_pkg::t_out_item i_res,
    output logic                o_full,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dsrm_pkg::t_out_item o_out_item
);
    import dsrm_pkg::*;

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_item r_out;
    t_out_item r_skid;
    logic      out_take;

    assign out_take = r_out_valid && !i_out_stall;

    // Valid flags. A new result only arrives while the skid entry is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_res_valid) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (i_res_valid) begin
            if (r_out_valid && !out_take) begin
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: rtl/dot_star_regex_matcher_top.sv
// ----------------------------------------------------------------------------
// dot_star_regex_matcher_top: streaming whole-string dot-star matcher
// Loads a pattern of literal bytes, '.' and 'x*' into a row of cells and
// reports, after each subject byte, whether the subject matches it fully.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless the input stalls: clear,
// append a pattern byte, start a subject, or feed a subject byte. Start and
// subject-byte items each give one result, registered in the output queue;
// clear and append give none. All cells of the row update together, and the
// cycle time is set by the match bit that ripples through consecutive star
// positions from the bottom of the row to the top. A two-entry output queue
// lets input items keep flowing while the output side stalls; the input
// stalls only when both entries are full. A leading star or an append beyond
// 32 bytes sets a sticky error that forces no match until the next clear.
module dot_star_regex_matcher_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dsrm_pkg::t_in_item i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dsrm_pkg::t_out_item o_out_item
);
    import dsrm_pkg::*;

    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             r_err;
    logic             n_err;
    logic             r_row0;
    logic             n_row0;
    logic             accept;
    logic             full;
    logic             q_full;
    logic             is_append;
    logic             row_en;
    logic             empty_mode;
    logic             res_valid;
    t_out_item        res;
    logic [PATTERN_MAX:0] new_bits;
    t_cell_link       links [PATTERN_MAX+1];
    t_cell_ctrl       ctrls [PATTERN_MAX];

    // Input handshake and command decode.
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;
    assign full       = (r_len == LEN_W'(PATTERN_MAX));
    assign is_append  = (i_in_item.cmd == CMD_APPEND);
    assign row_en     = accept && !(is_append && full);
    assign empty_mode = (i_in_item.cmd != CMD_SUBJECT);
    assign res_valid  = accept &&
                        ((i_in_item.cmd == CMD_START) || (i_in_item.cmd == CMD_SUBJECT));

    // Next pattern length and error flag.
    always_comb begin
        n_len = r_len;
        n_err = r_err;
        unique case (i_in_item.cmd)
            CMD_CLEAR: begin
                n_len = '0;
                n_err = 1'b0;
            end
            CMD_APPEND: begin
                if (full) begin
                    n_err = 1'b1;
                end else begin
                    n_len = r_len + LEN_W'(1);
                    if ((r_len == '0) && (i_in_item.data_byte == STAR_BYTE)) begin
                        n_err = 1'b1;
                    end
                end
            end
            CMD_START, CMD_SUBJECT: begin
                n_len = r_len;
            end
            default: begin
                n_len = r_len;
            end
        endcase
    end

    // Row bit zero: the empty prefix matches only the empty subject.
    assign n_row0 = empty_mode;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_err  <= 1'b0;
            r_row0 <= 1'b1;
        end else if (accept) begin
            r_len <= n_len;
            r_err <= n_err;
            if (row_en) begin
                r_row0 <= n_row0;
            end
        end
    end

    // Bottom of the chain stands in for row position zero.
    assign links[0].bit_new      = n_row0;
    assign links[0].bit_new_prev = 1'b0;
    assign links[0].bit_old      = r_row0;
    assign links[0].pat          = 8'h00;
    assign new_bits[0]           = n_row0;

    // Row of cells, one per pattern position.
    for (genvar j = 1; j <= PATTERN_MAX; j++) begin : g_cell
        assign ctrls[j-1].row_en     = row_en;
        assign ctrls[j-1].wr_en      = accept && is_append && !full &&
                                       (r_len == LEN_W'(j - 1));
        assign ctrls[j-1].active     = (LEN_W'(j) <= n_len);
        assign ctrls[j-1].first      = (j == 1);
        assign ctrls[j-1].empty_mode = empty_mode;

        dsrm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrls[j-1]),
            .i_data_byte (i_in_item.data_byte),
            .i_link      (links[j-1]),
            .o_link      (links[j])
        );

        assign new_bits[j] = links[j].bit_new;
    end

    // Result: the bit at the pattern length, masked by the error flag.
    assign res.matched       = new_bits[r_len] && !r_err;
    assign res.pattern_error = r_err;

    // Output queue.
    dsrm_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_full      (q_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: tb/sv/tb_dot_star_regex_matcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dot_star_regex_matcher_top: testbench of the dot-star matcher
// Loads patterns and streams subjects through the valid/stall input, predicts
// each match verdict with an in-bench copy of the match row, and checks every
// result in order while both sides idle at random outside a calm stretch.
// ----------------------------------------------------------------------------
module tb_dot_star_regex_matcher_top;
    import dsrm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1550;
    localparam int MAX_REPORTS    = 10;
    localparam int DRAIN_CYCLES   = 10;
    localparam int N_DIR          = 30;

    // Ordinary pattern and subject letters.
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;

    // One row of the directed stimulus; a typed verdict replaces the prediction.
    typedef struct {
        t_in_item  item;
        int        reps;
        bit        typed;
        t_out_item verdict;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    // Predicted state of the matcher.
    logic [7:0]             pat_mem [PATTERN_MAX];
    int                     pat_len    = 0;
    logic [PATTERN_MAX:0]   row_bits   = {{PATTERN_MAX{1'b0}}, 1'b1};
    bit                     err_sticky = 1'b0;

    // Verdicts still owed by the block, oldest first.
    t_out_item verdicts[$];

    int n_mismatch = 0;
    int n_sent     = 0;
    int stuck      = 0;
    bit calm       = 1'b0;

    // Directed stimulus: empty pattern, leading star, dot-star, star after star,
    // append during a subject, overflow of the store, and clear afterwards.
    t_dir_row dir_rows [N_DIR] = '{
        '{t_in_item'{CMD_START,   8'h00}, 1,  1'b1, t_out_item'{1'b1, 1'b0}},
        '{t_in_item'{CMD_SUBJECT, 8'hFF}, 1,  1'b1, t_out_item'{1'b0, 1'b0}},
        '{t_in_item'{CMD_SUBJECT, 8'h00}, 1,  1'b1, t_out_item'{1'b0, 1'b0}},
        '{t_in_item'{CMD_APPEND,  STAR_BYTE}, 1, 1'b0, '0},
        '{t_in_item'{CMD_START,   8'hFF}, 1,  1'b1, t_out_item'{1'b0, 1'b1}},
        '{t_in_item'{CMD_SUBJECT, STAR_BYTE}, 1, 1'b1, t_out_item'{1'b0, 1'b1}},
        '{t_in_item'{CMD_CLEAR,   8'hFF}, 1,  1'b0, '0},
        '{t_in_item'{CMD_APPEND,  CH_A},  1,  1'b0, '0},
        '{t_in_item'{CMD_APPEND,  STAR_BYTE}, 1, 1'b0, '0},
        '{t_in_item'{CMD_APPEND,  DOT_BYTE},  1, 1'b0, '0},
        '{t_in_item'{CMD_APPEND,  STAR_BYTE}, 1, 1'b0, '0},
        '{t_in_item'{CMD_START,   8'h00}, 1,  1'b0, '0},
        '{t_in_item'{CMD_SUBJECT, 8'h00}, 1,  1'b0, '0},
        '{t_in_item'{CMD_SUBJECT, 8'hFF}, 1,  1'b0, '0},
        '{t_in_item'{CMD_CLEAR,   8'h00}, 1,  1'b0, '0},
        '{t_in_item'{CMD_APPEND,  CH_A},  1,  1'b0, '0},
        '{t_in_item'{CMD_APPEND,  STAR_BYTE}, 1, 1'b0, '0},
        '{t_in_item'{CMD_APPEND,  STAR_BYTE}, 1, 1'b0, '0},
        '{t_in_item'{CMD_START,   8'h00}, 1,  1'b0, '0},
        '{t_in_item'{CMD_SUBJECT, CH_A},  1,  1'b0, '0},
        '{t_in_item'{CMD_SUBJECT, STAR_BYTE}, 1, 1'b0, '0},
        '{t_in_item'{CMD_SUBJECT, STAR_BYTE}, 1, 1'b0, '0},
        '{t_in_item'{CMD_SUBJECT, CH_A},  1,  1'b0, '0},
        '{t_in_item'{CMD_APPEND,  CH_B},  1,  1'b0, '0},
        '{t_in_item'{CMD_SUBJECT, CH_B},  1,  1'b0, '0},
        '{t_in_item'{CMD_CLEAR,   8'h00}, 1,  1'b0, '0},
        '{t_in_item'{CMD_APPEND,  DOT_BYTE}, PATTERN_MAX + 1, 1'b0, '0},
        '{t_in_item'{CMD_START,   8'h00}, 1,  1'b1, t_out_item'{1'b0, 1'b1}},
        '{t_in_item'{CMD_CLEAR,   8'h00}, 1,  1'b0, '0},
        '{t_in_item'{CMD_START,   8'h00}, 1,  1'b1, t_out_item'{1'b1, 1'b0}}
    };

    dot_star_regex_matcher_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // Pattern byte at an index; entries past the length read as zero.
    function automatic logic [7:0] pat_byte(int idx);
        return (idx < pat_len) ? pat_mem[idx] : 8'h00;
    endfunction

    function automatic bit byte_fits(logic [7:0] c, logic [7:0] p);
        return (p == DOT_BYTE) || (p == c);
    endfunction

    // Row for the empty subject: only stars can extend a match past bit zero.
    function automatic logic [PATTERN_MAX:0] blank_row();
        logic [PATTERN_MAX:0] r;
        r = {{PATTERN_MAX{1'b0}}, 1'b1};
        for (int j = 1; j <= pat_len; j++) begin
            if (j > 1 && pat_byte(j - 1) == STAR_BYTE && r[j - 2])
                r[j] = 1'b1;
        end
        return r;
    endfunction

    // Row after one more subject byte.
    function automatic logic [PATTERN_MAX:0] advance_row(logic [PATTERN_MAX:0] old,
                                                         logic [7:0] c);
        logic [PATTERN_MAX:0] r;
        logic [7:0]           p;
        r = '0;
        for (int j = 1; j <= pat_len; j++) begin
            p = pat_byte(j - 1);
            if (p != STAR_BYTE) begin
                r[j] = old[j - 1] && byte_fits(c, p);
            end else if (j >= 2) begin
                r[j] = r[j - 2] || (byte_fits(c, pat_byte(j - 2)) && old[j]);
            end
        end
        return r;
    endfunction

    // Applies one item to the predicted state; returns 1 when it gives a verdict.
    function automatic bit dot_star_step(t_in_item it, output t_out_item verdict);
        verdict = '0;
        case (it.cmd)
            CMD_CLEAR: begin
                pat_len    = 0;
                err_sticky = 1'b0;
                row_bits   = {{PATTERN_MAX{1'b0}}, 1'b1};
                return 1'b0;
            end
            CMD_APPEND: begin
                if (pat_len >= PATTERN_MAX) begin
                    err_sticky = 1'b1;
                    return 1'b0;
                end
                if (pat_len == 0 && it.data_byte == STAR_BYTE)
                    err_sticky = 1'b1;
                pat_mem[pat_len] = it.data_byte;
                pat_len++;
                row_bits = blank_row();
                return 1'b0;
            end
            CMD_START: row_bits = blank_row();
            default:   row_bits = advance_row(row_bits, it.data_byte);
        endcase
        verdict.matched       = err_sticky ? 1'b0 : row_bits[pat_len];
        verdict.pattern_error = err_sticky;
        return 1'b1;
    endfunction

    // Letter, dot or fully random byte for patterns and subjects.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 40) return CH_A;
        if (r < 70) return CH_B;
        if (r < 82) return DOT_BYTE;
        return 8'($urandom_range(255));
    endfunction

    task automatic flag_mismatch(string what, t_out_item want, t_out_item got);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
            $display("%0t: %s: expected matched=%0b error=%0b, got matched=%0b error=%0b",
                     $time, what, want.matched, want.pattern_error,
                     got.matched, got.pattern_error);
    endtask

    // Offers one item, holding it until the block takes it.
    task automatic send(t_in_item it, bit typed, t_out_item typed_verdict);
        t_out_item predicted;
        if (!calm) begin
            while ($urandom_range(99) < 24) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
        if (dot_star_step(it, predicted))
            verdicts.push_back(typed ? typed_verdict : predicted);
    endtask

    // Output side stalls at random outside the calm stretch.
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 24);
    end

    // Each accepted result is checked against the oldest owed verdict.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdicts.size() == 0) begin
                flag_mismatch("result with nothing owed", '0, o_out_item);
            end else begin
                want = verdicts.pop_front();
                if (o_out_item.matched !== want.matched ||
                    o_out_item.pattern_error !== want.pattern_error)
                    flag_mismatch("verdict differs", want, o_out_item);
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck <= 0;
        end else if (stuck >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    initial begin
        logic [7:0] pat_q[$];
        logic [7:0] subj_q[$];
        logic [7:0] e;
        int         base;
        int         plen;
        int         n_subj;
        int         r;
        int         i;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        foreach (dir_rows[d]) begin
            for (int k = 0; k < dir_rows[d].reps; k++)
                send(dir_rows[d].item, dir_rows[d].typed, dir_rows[d].verdict);
        end

        // Random part: mostly a pattern load followed by subjects built to match it.
        base = n_sent;
        while (n_sent - base < RANDOM_ITEMS) begin
            calm = (n_sent - base >= 600) && (n_sent - base < 900);
            if ($urandom_range(99) < 8) begin
                send(t_in_item'{2'($urandom_range(3)), 8'($urandom_range(255))}, 1'b0, '0);
                continue;
            end

            // Pattern, usually short, now and then up to and past the store size.
            r = $urandom_range(99);
            if (r < 85)      plen = $urandom_range(1, 8);
            else if (r < 95) plen = $urandom_range(9, PATTERN_MAX - 1);
            else             plen = $urandom_range(PATTERN_MAX, PATTERN_MAX + 2);
            if ($urandom_range(99) < 90)
                send(t_in_item'{CMD_CLEAR, 8'($urandom_range(255))}, 1'b0, '0);
            pat_q.delete();
            for (int k = 0; k < plen; k++) begin
                if (k == 0 && $urandom_range(99) < 4)
                    e = STAR_BYTE;
                else if (k > 0 && (pat_q[k - 1] != STAR_BYTE || $urandom_range(99) < 10)
                         && $urandom_range(99) < 35)
                    e = STAR_BYTE;
                else
                    e = pick_byte();
                pat_q.push_back(e);
                send(t_in_item'{CMD_APPEND, e}, 1'b0, '0);
            end

            // Subjects: a matching string, sometimes spoiled by one edit.
            n_subj = $urandom_range(1, 3);
            for (int s = 0; s < n_subj; s++) begin
                subj_q.delete();
                i = 0;
                while (i < pat_q.size()) begin
                    e = pat_q[i];
                    if (i + 1 < pat_q.size() && pat_q[i + 1] == STAR_BYTE) begin
                        repeat ($urandom_range(0, 3))
                            subj_q.push_back(e == DOT_BYTE ? 8'($urandom_range(255)) : e);
                        i += 2;
                    end else begin
                        subj_q.push_back(e == DOT_BYTE ? 8'($urandom_range(255)) : e);
                        i++;
                    end
                end
                if ($urandom_range(99) < 30) begin
                    r = $urandom_range(2);
                    if (r == 0 && subj_q.size() > 0)
                        subj_q[$urandom_range(subj_q.size() - 1)] = pick_byte();
                    else if (r == 1 && subj_q.size() > 0)
                        void'(subj_q.pop_back());
                    else
                        subj_q.push_back(pick_byte());
                end
                // Leaving out the start relies on the row that the last append set.
                if (s > 0 || $urandom_range(99) < 85)
                    send(t_in_item'{CMD_START, 8'($urandom_range(255))}, 1'b0, '0);
                foreach (subj_q[k])
                    send(t_in_item'{CMD_SUBJECT, subj_q[k]}, 1'b0, '0);
            end
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // Let every owed verdict arrive, then watch for strays.
        while (verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
